### design/tbgs_pkg.sv
// shared types, constants and codes of the two-body gravity stepper
package tbgs_pkg;

   localparam int WORD_WIDTH_DEF = 48;
   localparam int FRAC_BITS_DEF = 16;

   localparam int FIELD_W = 48;
   localparam int CFG_W = 32;
   localparam int DT_W = 24;
   localparam int DT_FRAC = 16;
   localparam int NUM_SHIFT = 32;

   localparam int ARG_W = 128;
   localparam int ROOT_W = 64;
   localparam int DIV_BITS = 120;
   localparam int DIV_PAD = ARG_W - DIV_BITS;
   localparam int CNT_W = 7;

   localparam logic [CFG_W-1:0] GRAV_RESET = 32'd28664612;
   localparam logic [CFG_W-1:0] MASS_ONE_RESET = 32'd1000000;
   localparam logic [CFG_W-1:0] MASS_TWO_RESET = 32'd5000000;

   localparam logic [1:0] CSR_GRAV = 2'd0;
   localparam logic [1:0] CSR_MASS_ONE = 2'd1;
   localparam logic [1:0] CSR_MASS_TWO = 2'd2;

   typedef enum logic [1:0] {
      ST_STEPPED    = 2'd0,
      ST_LOADED     = 2'd1,
      ST_COINCIDENT = 2'd2,
      ST_SATURATED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      UOP_SQX  = 4'd0,
      UOP_SQY  = 4'd1,
      UOP_ROOT = 4'd2,
      UOP_GM   = 4'd3,
      UOP_NUM  = 4'd4,
      UOP_DIV1 = 4'd5,
      UOP_DIV2 = 4'd6,
      UOP_AXIS = 4'd7,
      UOP_VEL  = 4'd8,
      UOP_POS  = 4'd9
   } uop_type;

   typedef struct packed {
      logic       take_load;
      logic       take_step;
      logic       sep;
      logic       start;
      logic       capture;
      uop_type    uop;
      logic [1:0] idx;
      logic       out_load;
      status_type out_status;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic res_zero;
      logic sat;
   } stat_type;

endpackage

### design/two_body_gravity_step_top.sv
// top level of the two-body gravity stepper
// a load word is taken and its result word is registered from the finish state once the
// result register is free; a step word runs on one shared iterative unit: a root,
// eight divides, shift-add multiplies that stop once no multiplier bits remain;
// coincident bodies end after the root; one word in work at a time, the result register
// frees the input side; synchronous reset zeroes both bodies and restores the config
module two_body_gravity_step_top #(
   parameter int WORD_WIDTH = tbgs_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS = tbgs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic                                req_body_select,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_pos_x,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_pos_y,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_vel_x,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_vel_y,
   input  logic [tbgs_pkg::DT_W-1:0]           req_delta_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_one_pos_x,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_one_pos_y,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_one_vel_x,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_one_vel_y,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_two_pos_x,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_two_pos_y,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_two_vel_x,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_two_vel_y,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [tbgs_pkg::CFG_W-1:0]          csr_data
);
   import tbgs_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic signed [FIELD_W-1:0] pos [4];
   logic signed [FIELD_W-1:0] vel [4];

   assign csr_ready = 1'b1;

   tbgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tbgs_dp #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_write       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_body_select (req_body_select),
      .req_load_pos_x  (req_load_pos_x),
      .req_load_pos_y  (req_load_pos_y),
      .req_load_vel_x  (req_load_vel_x),
      .req_load_vel_y  (req_load_vel_y),
      .req_delta_time  (req_delta_time),
      .rsp_pos         (pos),
      .rsp_vel         (vel),
      .rsp_status      (rsp_status)
   );

   assign rsp_one_pos_x = pos[0];
   assign rsp_one_pos_y = pos[1];
   assign rsp_one_vel_x = vel[0];
   assign rsp_one_vel_y = vel[1];
   assign rsp_two_pos_x = pos[2];
   assign rsp_two_pos_y = pos[3];
   assign rsp_two_vel_x = vel[2];
   assign rsp_two_vel_y = vel[3];

endmodule

### design/tbgs_iter.sv
// shared iterative unit: shift-add multiply, restoring divide, digit square root
module tbgs_iter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  tbgs_pkg::op_type          op,
   input  logic [tbgs_pkg::ARG_W-1:0]  opa,
   input  logic [tbgs_pkg::ROOT_W-1:0] opb,
   output logic                      done,
   output logic [tbgs_pkg::ARG_W-1:0]  result
);
   import tbgs_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   op_type            op_ff, op_in;
   logic [ARG_W-1:0]  sh_ff, sh_in;
   logic [ARG_W-1:0]  acc_ff, acc_in;
   logic [ROOT_W-1:0] bsh_ff, bsh_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [ROOT_W:0]   r2d;
   logic [ROOT_W+2:0] r2s;
   logic [ROOT_W+2:0] trial;
   logic              ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      sh_in = sh_ff;
      acc_in = acc_ff;
      bsh_in = bsh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      r2d = {rem_ff[ROOT_W-1:0], sh_ff[ARG_W-1]};
      r2s = {rem_ff[ROOT_W:0], sh_ff[ARG_W-1:ARG_W-2]};
      trial = {1'b0, acc_ff[ROOT_W-1:0], 2'b01};
      ge = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         op_in = op;
         acc_in = '0;
         rem_in = '0;
         bsh_in = opb;
         case (op)
            OP_DIV: begin
               sh_in = opa << DIV_PAD;
               cnt_in = CNT_W'(DIV_BITS - 1);
            end
            OP_SQRT: begin
               sh_in = opa;
               cnt_in = CNT_W'(ROOT_W - 1);
            end
            default: begin
               sh_in = opa;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            OP_DIV: begin
               ge = (r2d >= {1'b0, bsh_ff});
               rem_in = (ROOT_W+2)'(ge ? (r2d - {1'b0, bsh_ff}) : r2d);
               sh_in = {sh_ff[ARG_W-2:0], ge};
               if (cnt_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            OP_SQRT: begin
               ge = (r2s >= trial);
               rem_in = (ROOT_W+2)'(ge ? (r2s - trial) : r2s);
               acc_in = {acc_ff[ARG_W-2:0], ge};
               sh_in = sh_ff << 2;
               if (cnt_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            OP_MUL: begin
               // stops as soon as no multiplier bits remain
               if (bsh_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  acc_in = acc_ff + (bsh_ff[0] ? sh_ff : '0);
                  sh_in = sh_ff << 1;
                  bsh_in = bsh_ff >> 1;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (op_ff)
         OP_DIV:  result = ARG_W'(sh_ff[DIV_BITS-1:0]);
         OP_SQRT: result = ARG_W'(acc_ff[ROOT_W-1:0]);
         default: result = acc_ff;
      endcase
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      sh_ff <= sh_in;
      acc_ff <= acc_in;
      bsh_ff <= bsh_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

endmodule

### design/tbgs_dp.sv
// datapath: body state, configuration, operand selection and saturating updates
module tbgs_dp #(
   parameter int WORD_WIDTH = tbgs_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS = tbgs_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tbgs_pkg::cmd_type                cmd,
   output tbgs_pkg::stat_type               stat,
   input  logic                             csr_write,
   input  logic [1:0]                       csr_index,
   input  logic [tbgs_pkg::CFG_W-1:0]       csr_data,
   input  logic                             req_body_select,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_pos_x,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_pos_y,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_vel_x,
   input  logic signed [tbgs_pkg::FIELD_W-1:0] req_load_vel_y,
   input  logic [tbgs_pkg::DT_W-1:0]        req_delta_time,
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_pos [4],
   output logic signed [tbgs_pkg::FIELD_W-1:0] rsp_vel [4],
   output logic [1:0]                       rsp_status
);
   import tbgs_pkg::*;

   localparam int W = WORD_WIDTH;
   localparam int SW = WORD_WIDTH + 2;
   localparam int DW = WORD_WIDTH + 1;
   localparam int PULL_SH = 64 - 2 * FRAC_BITS;
   localparam logic [ROOT_W-1:0] MAG_CLAMP = {1'b0, {(ROOT_W-1){1'b1}}};

   function automatic logic [WORD_WIDTH:0] sat_add(input logic signed [WORD_WIDTH-1:0] base,
                                                   input logic dneg,
                                                   input logic [ARG_W-1:0] dmag);
      logic                  big;
      logic [WORD_WIDTH:0]   dm;
      logic signed [SW-1:0]  be;
      logic signed [SW-1:0]  de;
      logic signed [SW-1:0]  sum;
      logic                  fits;
      big = |(dmag >> WORD_WIDTH);
      dm = big ? {1'b1, {WORD_WIDTH{1'b0}}} : {1'b0, dmag[WORD_WIDTH-1:0]};
      be = SW'(base);
      de = signed'({1'b0, dm});
      if (dneg) de = -de;
      sum = be + de;
      fits = (sum[SW-1:WORD_WIDTH-1] == '0) || (sum[SW-1:WORD_WIDTH-1] == '1);
      if (fits) return {1'b0, sum[WORD_WIDTH-1:0]};
      else if (sum[SW-1]) return {1'b1, 1'b1, {(WORD_WIDTH-1){1'b0}}};
      else return {1'b1, 1'b0, {(WORD_WIDTH-1){1'b1}}};
   endfunction

   function automatic logic signed [WORD_WIDTH-1:0] load_clamp(
      input logic signed [FIELD_W-1:0] f);
      logic [FIELD_W:0]    ext;
      logic [FIELD_W:0]    mag;
      logic [WORD_WIDTH:0] r;
      ext = {f[FIELD_W-1], f};
      mag = f[FIELD_W-1] ? ('0 - ext) : ext;
      r = sat_add('0, f[FIELD_W-1], ARG_W'(mag));
      return r[WORD_WIDTH-1:0];
   endfunction

   logic signed [W-1:0] pos_ff [4];
   logic signed [W-1:0] pos_in [4];
   logic signed [W-1:0] vel_ff [4];
   logic signed [W-1:0] vel_in [4];
   logic [CFG_W-1:0]    grav_ff, grav_in;
   logic [CFG_W-1:0]    m1_ff, m1_in;
   logic [CFG_W-1:0]    m2_ff, m2_in;
   logic [DT_W-1:0]     dt_ff, dt_in;
   logic [ROOT_W-1:0]   mag_ff [2];
   logic [ROOT_W-1:0]   mag_in [2];
   logic                neg_ff [2];
   logic                neg_in [2];
   logic                sat_ff, sat_in;
   logic [ARG_W-1:0]    tmp_ff, tmp_in;
   logic [ROOT_W-1:0]   r_ff, r_in;
   logic [ROOT_W-1:0]   gm_ff, gm_in;
   logic [ARG_W-1:0]    num_ff, num_in;
   logic [ARG_W-1:0]    q_ff, q_in;

   logic signed [FIELD_W-1:0] opos_ff [4];
   logic signed [FIELD_W-1:0] ovel_ff [4];
   logic [1:0]                ostat_ff;

   op_type              op;
   logic [ARG_W-1:0]    opa;
   logic [ROOT_W-1:0]   opb;
   logic                unit_done;
   logic [ARG_W-1:0]    res;

   logic signed [DW-1:0] diff [2];
   logic [DW-1:0]        dabs [2];
   logic [ROOT_W-1:0]    mag64 [2];
   logic [W:0]           upd;
   logic [W-1:0]         vabs;
   logic [1:0]           lo, hi;

   tbgs_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .op     (op),
      .opa    (opa),
      .opb    (opb),
      .done   (unit_done),
      .result (res)
   );

   // operand selection for the shared unit
   always_comb begin
      vabs = vel_ff[cmd.idx][W-1] ? W'(-vel_ff[cmd.idx]) : W'(vel_ff[cmd.idx]);
      op = OP_MUL;
      opa = '0;
      opb = '0;
      case (cmd.uop)
         UOP_SQX: begin
            opa = ARG_W'(mag_ff[0]);
            opb = mag_ff[0];
         end
         UOP_SQY: begin
            opa = ARG_W'(mag_ff[1]);
            opb = mag_ff[1];
         end
         UOP_ROOT: begin
            op = OP_SQRT;
            opa = tmp_ff;
         end
         UOP_GM: begin
            opa = ARG_W'(grav_ff);
            opb = ROOT_W'(cmd.idx[1] ? m1_ff : m2_ff);
         end
         UOP_NUM: begin
            opa = ARG_W'(gm_ff);
            opb = ROOT_W'(dt_ff);
         end
         UOP_DIV1, UOP_DIV2, UOP_VEL: begin
            op = OP_DIV;
            opa = num_ff;
            opb = r_ff;
         end
         UOP_AXIS: begin
            opa = q_ff;
            opb = mag_ff[cmd.idx[0]];
         end
         UOP_POS: begin
            opa = ARG_W'(vabs);
            opb = ROOT_W'(dt_ff);
         end
         default: begin
            op = OP_MUL;
         end
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      vel_in = vel_ff;
      grav_in = grav_ff;
      m1_in = m1_ff;
      m2_in = m2_ff;
      dt_in = dt_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      sat_in = sat_ff;
      tmp_in = tmp_ff;
      r_in = r_ff;
      gm_in = gm_ff;
      num_in = num_ff;
      q_in = q_ff;
      upd = '0;
      lo = {req_body_select, 1'b0};
      hi = {req_body_select, 1'b1};
      for (int i = 0; i < 2; i++) begin
         diff[i] = DW'(pos_ff[2+i]) - DW'(pos_ff[i]);
         dabs[i] = diff[i][W] ? DW'(-diff[i]) : DW'(diff[i]);
         mag64[i] = ROOT_W'(dabs[i][W-1:0]);
      end

      if (csr_write) begin
         case (csr_index)
            CSR_GRAV:     grav_in = csr_data;
            CSR_MASS_ONE: m1_in = csr_data;
            CSR_MASS_TWO: m2_in = csr_data;
            default:      ;
         endcase
      end

      if (cmd.take_load) begin
         pos_in[lo] = load_clamp(req_load_pos_x);
         pos_in[hi] = load_clamp(req_load_pos_y);
         vel_in[lo] = load_clamp(req_load_vel_x);
         vel_in[hi] = load_clamp(req_load_vel_y);
      end

      if (cmd.take_step) begin
         dt_in = req_delta_time;
         sat_in = 1'b0;
      end

      // separation, pointing from body one to body two
      if (cmd.sep) begin
         for (int i = 0; i < 2; i++) begin
            neg_in[i] = diff[i][W];
            if (mag64[i][ROOT_W-1]) begin
               mag_in[i] = MAG_CLAMP;
               sat_in = 1'b1;
            end else begin
               mag_in[i] = mag64[i];
            end
         end
      end

      if (cmd.capture) begin
         case (cmd.uop)
            UOP_SQX:  tmp_in = res;
            UOP_SQY:  tmp_in = tmp_ff + res;
            UOP_ROOT: r_in = res[ROOT_W-1:0];
            UOP_GM:   gm_in = res[ROOT_W-1:0];
            UOP_NUM:  num_in = res << NUM_SHIFT;
            UOP_DIV1: num_in = res;
            UOP_DIV2: q_in = res;
            UOP_AXIS: num_in = res;
            UOP_VEL: begin
               // body two is pulled the opposite way
               upd = sat_add(vel_ff[cmd.idx], neg_ff[cmd.idx[0]] ^ cmd.idx[1], res >> PULL_SH);
               vel_in[cmd.idx] = upd[W-1:0];
               sat_in = sat_ff | upd[W];
            end
            UOP_POS: begin
               upd = sat_add(pos_ff[cmd.idx], vel_ff[cmd.idx][W-1], res >> DT_FRAC);
               pos_in[cmd.idx] = upd[W-1:0];
               sat_in = sat_ff | upd[W];
            end
            default: ;
         endcase
      end
   end

   assign stat.done = unit_done;
   assign stat.res_zero = (res[ROOT_W-1:0] == '0);
   assign stat.sat = sat_ff;

   assign rsp_pos = opos_ff;
   assign rsp_vel = ovel_ff;
   assign rsp_status = ostat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
         grav_ff <= GRAV_RESET;
         m1_ff <= MASS_ONE_RESET;
         m2_ff <= MASS_TWO_RESET;
      end else begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         grav_ff <= grav_in;
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      tmp_ff <= tmp_in;
      r_ff <= r_in;
      gm_ff <= gm_in;
      num_ff <= num_in;
      q_ff <= q_in;
      if (cmd.out_load) begin
         for (int i = 0; i < 4; i++) begin
            opos_ff[i] <= FIELD_W'(pos_ff[i]);
            ovel_ff[i] <= FIELD_W'(vel_ff[i]);
         end
         ostat_ff <= cmd.out_status;
      end
   end

endmodule

### design/tbgs_ctrl.sv
// controller: sequences one load or one time step through the datapath
module tbgs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tbgs_pkg::stat_type  stat,
   output tbgs_pkg::cmd_type   cmd
);
   import tbgs_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE = 13'h0001,
      S_SEP  = 13'h0002,
      S_SQX  = 13'h0004,
      S_SQY  = 13'h0008,
      S_ROOT = 13'h0010,
      S_GM   = 13'h0020,
      S_NUM  = 13'h0040,
      S_DIV1 = 13'h0080,
      S_DIV2 = 13'h0100,
      S_AXIS = 13'h0200,
      S_VEL  = 13'h0400,
      S_POS  = 13'h0800,
      S_FIN  = 13'h1000
   } fsm_type;

   fsm_type    state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       started_ff, started_in;
   status_type fin_ff, fin_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       op_go;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      started_in = started_ff;
      fin_in = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      op_go = 1'b0;
      cmd = '0;
      cmd.uop = UOP_SQX;
      cmd.idx = idx_ff;
      cmd.out_status = (fin_ff == ST_STEPPED && stat.sat) ? ST_SATURATED : fin_ff;
      if (!rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type) begin
                  cmd.take_load = 1'b1;
                  fin_in = ST_LOADED;
                  state_in = S_FIN;
               end else begin
                  cmd.take_step = 1'b1;
                  state_in = S_SEP;
               end
            end
         end
         S_SEP: begin
            cmd.sep = 1'b1;
            idx_in = 2'd0;
            state_in = S_SQX;
         end
         S_SQX: begin
            op_go = 1'b1;
            cmd.uop = UOP_SQX;
            if (stat.done) state_in = S_SQY;
         end
         S_SQY: begin
            op_go = 1'b1;
            cmd.uop = UOP_SQY;
            if (stat.done) state_in = S_ROOT;
         end
         S_ROOT: begin
            op_go = 1'b1;
            cmd.uop = UOP_ROOT;
            if (stat.done) begin
               if (stat.res_zero) begin
                  fin_in = ST_COINCIDENT;
                  state_in = S_FIN;
               end else begin
                  state_in = S_GM;
               end
            end
         end
         S_GM: begin
            op_go = 1'b1;
            cmd.uop = UOP_GM;
            if (stat.done) state_in = S_NUM;
         end
         S_NUM: begin
            op_go = 1'b1;
            cmd.uop = UOP_NUM;
            if (stat.done) state_in = S_DIV1;
         end
         S_DIV1: begin
            op_go = 1'b1;
            cmd.uop = UOP_DIV1;
            if (stat.done) state_in = S_DIV2;
         end
         S_DIV2: begin
            op_go = 1'b1;
            cmd.uop = UOP_DIV2;
            if (stat.done) state_in = S_AXIS;
         end
         S_AXIS: begin
            op_go = 1'b1;
            cmd.uop = UOP_AXIS;
            if (stat.done) state_in = S_VEL;
         end
         S_VEL: begin
            op_go = 1'b1;
            cmd.uop = UOP_VEL;
            // idx walks body one x, y then body two x, y
            if (stat.done) begin
               if (idx_ff == 2'd3) begin
                  idx_in = 2'd0;
                  state_in = S_POS;
               end else begin
                  idx_in = idx_ff + 2'd1;
                  state_in = idx_ff[0] ? S_GM : S_AXIS;
               end
            end
         end
         S_POS: begin
            op_go = 1'b1;
            cmd.uop = UOP_POS;
            if (stat.done) begin
               if (idx_ff == 2'd3) begin
                  fin_in = ST_STEPPED;
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (op_go) begin
         cmd.start = !started_ff;
         cmd.capture = stat.done;
         if (cmd.start) started_in = 1'b1;
         else if (stat.done) started_in = 1'b0;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= 2'd0;
         started_ff <= 1'b0;
         fin_ff <= ST_STEPPED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         started_ff <= started_in;
         fin_ff <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### tb/testbench.sv
// self-checking testbench of the two-body gravity stepper with a built-in fixed-point predictor
`timescale 1ns / 100ps

module testbench;
   import tbgs_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;
   localparam logic [63:0] HALF_RANGE = 64'h1 << 47;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_WORDS = 280;

   typedef struct {
      bit              is_load;
      bit              body;
      logic [47:0]     px, py, vx, vy;
      logic [23:0]     dt;
      bit              typed;
      status_type      st;
   } stim_row_type;

   typedef struct {
      logic [47:0] f[8];
      status_type  st;
   } state_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_type = 0, req_body_select = 0;
   logic signed [47:0] req_load_pos_x = 0, req_load_pos_y = 0;
   logic signed [47:0] req_load_vel_x = 0, req_load_vel_y = 0;
   logic [23:0] req_delta_time = 0;
   logic req_stall, rsp_valid, csr_ready;
   logic rsp_stall = 0;
   logic signed [47:0] rsp_one_pos_x, rsp_one_pos_y, rsp_one_vel_x, rsp_one_vel_y;
   logic signed [47:0] rsp_two_pos_x, rsp_two_pos_y, rsp_two_vel_x, rsp_two_vel_y;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   two_body_gravity_step_top i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor state: sign-extended to 64 bits, layout one x, one y, two x, two y
   logic [63:0] body_pos[4];
   logic [63:0] body_vel[4];
   logic [31:0] g_frac, mass_a, mass_b;

   state_word_type pending_q[$];
   stim_row_type plan[$];
   int errors = 0;
   bit quiet = 0;
   int idle_cycles = 0;

   function automatic logic [63:0] clamp_add(input logic [63:0] base, input bit dneg,
                                             input logic [127:0] dmag, inout bit sat);
      bit bneg, rneg, big;
      logic [63:0] bmag, rmag, lim;
      logic [127:0] sum;
      bneg = base[63];
      bmag = bneg ? -base : base;
      big = 0;
      rmag = 0;
      if (bneg == dneg) begin
         sum = {64'b0, bmag} + dmag;
         big = sum[127:64] != 0;
         rmag = sum[63:0];
         rneg = bneg;
      end else if (dmag[127:64] != 0) begin
         rneg = dneg;
         big = 1;
      end else if (dmag[63:0] >= bmag) begin
         rneg = dneg;
         rmag = dmag[63:0] - bmag;
      end else begin
         rneg = bneg;
         rmag = bmag - dmag[63:0];
      end
      if (!big && rmag == 0) rneg = 0;
      lim = rneg ? HALF_RANGE : HALF_RANGE - 1;
      if (big || rmag > lim) begin
         rmag = lim;
         sat = 1;
      end
      return rneg ? -rmag : rmag;
   endfunction

   function automatic logic [63:0] root_floor(input logic [127:0] v);
      logic [63:0] res, cand;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'h1 << b);
         if ({64'b0, cand} * {64'b0, cand} <= v) res = cand;
      end
      return res;
   endfunction

   function automatic logic [127:0] pull_mag(input logic [63:0] gm, input logic [23:0] dt,
                                             input logic [63:0] axis, input logic [63:0] r);
      logic [127:0] q;
      q = ({64'b0, gm} * {104'b0, dt}) << 32;
      q = q / {64'b0, r};
      q = q / {64'b0, r};
      q = (q * {64'b0, axis}) / {64'b0, r};
      return q >> 32;
   endfunction

   function automatic state_word_type advance(input stim_row_type w);
      state_word_type res;
      logic [63:0] mag[2], r, gm1, gm2, a, b;
      bit neg[2], sat, vneg;
      logic [127:0] d2;
      int base;
      sat = 0;
      if (w.is_load) begin
         base = w.body ? 2 : 0;
         body_pos[base] = {{16{w.px[47]}}, w.px};
         body_pos[base+1] = {{16{w.py[47]}}, w.py};
         body_vel[base] = {{16{w.vx[47]}}, w.vx};
         body_vel[base+1] = {{16{w.vy[47]}}, w.vy};
         res.st = ST_LOADED;
      end else begin
         for (int i = 0; i < 2; i++) begin
            a = body_pos[2+i];
            b = body_pos[i];
            neg[i] = $signed(a) < $signed(b);
            mag[i] = neg[i] ? b - a : a - b;
            if (mag[i][63]) begin
               mag[i] = 64'h7FFF_FFFF_FFFF_FFFF;
               sat = 1;
            end
         end
         d2 = {64'b0, mag[0]} * {64'b0, mag[0]} + {64'b0, mag[1]} * {64'b0, mag[1]};
         r = root_floor(d2);
         if (r == 0) begin
            res.st = ST_COINCIDENT;
         end else begin
            gm1 = {32'b0, g_frac} * {32'b0, mass_b};
            gm2 = {32'b0, g_frac} * {32'b0, mass_a};
            for (int i = 0; i < 2; i++) begin
               body_vel[i] = clamp_add(body_vel[i], neg[i],
                                       pull_mag(gm1, w.dt, mag[i], r), sat);
               body_vel[2+i] = clamp_add(body_vel[2+i], !neg[i],
                                         pull_mag(gm2, w.dt, mag[i], r), sat);
            end
            for (int i = 0; i < 4; i++) begin
               vneg = body_vel[i][63];
               a = vneg ? -body_vel[i] : body_vel[i];
               body_pos[i] = clamp_add(body_pos[i], vneg,
                                       ({64'b0, a} * {104'b0, w.dt}) >> DT_FRAC, sat);
            end
            res.st = sat ? ST_SATURATED : ST_STEPPED;
         end
      end
      res.f[0] = body_pos[0][47:0];
      res.f[1] = body_pos[1][47:0];
      res.f[2] = body_vel[0][47:0];
      res.f[3] = body_vel[1][47:0];
      res.f[4] = body_pos[2][47:0];
      res.f[5] = body_pos[3][47:0];
      res.f[6] = body_vel[2][47:0];
      res.f[7] = body_vel[3][47:0];
      return res;
   endfunction

   function automatic stim_row_type row(input bit ld, input bit body, input logic [47:0] px,
                                        input logic [47:0] py, input logic [47:0] vx,
                                        input logic [47:0] vy, input logic [23:0] dt,
                                        input bit typed, input status_type st);
      stim_row_type w;
      w.is_load = ld; w.body = body;
      w.px = px; w.py = py; w.vx = vx; w.vy = vy; w.dt = dt;
      w.typed = typed; w.st = st;
      return w;
   endfunction

   function automatic logic [47:0] rand_fix();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) return w[47:0];
      w = w >> $urandom_range(18, 63);
      if ($urandom_range(0, 1)) w = -w;
      return w[47:0];
   endfunction

   function automatic logic [23:0] rand_dt();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: return w[23:0];
         1: return 24'd0;
         default: return 24'($urandom_range(1, 1 << 17));
      endcase
   endfunction

   task automatic send(input stim_row_type w);
      state_word_type e;
      @(negedge clock);
      req_valid = 1;
      req_type = w.is_load;
      req_body_select = w.body;
      req_load_pos_x = w.px;
      req_load_pos_y = w.py;
      req_load_vel_x = w.vx;
      req_load_vel_y = w.vy;
      req_delta_time = w.dt;
      do @(posedge clock); while (req_stall);
      e = advance(w);
      if (w.typed) e.st = w.st;
      pending_q.push_back(e);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat ($urandom_range(1, 8) - 1) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      // no word may be offered again while the block drains
      @(negedge clock);
      req_valid = 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GRAV: g_frac = value;
         CSR_MASS_ONE: mass_a = value;
         CSR_MASS_TWO: mass_b = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   // random bursts of result back-pressure
   int stall_left = 0;
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      state_word_type e;
      logic [47:0] got[8];
      string names[8];
      if (!reset && rsp_valid && !rsp_stall) begin
         names = '{"one_pos_x", "one_pos_y", "one_vel_x", "one_vel_y",
                   "two_pos_x", "two_pos_y", "two_vel_x", "two_vel_y"};
         got = '{rsp_one_pos_x, rsp_one_pos_y, rsp_one_vel_x, rsp_one_vel_y,
                 rsp_two_pos_x, rsp_two_pos_y, rsp_two_vel_x, rsp_two_vel_y};
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result word, status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = pending_q.pop_front();
            for (int i = 0; i < 8; i++)
               if (got[i] !== e.f[i]) begin
                  $display("%0t: %s expected %h actual %h", $time, names[i], e.f[i], got[i]);
                  errors++;
               end
            if (rsp_status !== e.st) begin
               $display("%0t: status expected %0d actual %0d", $time, e.st, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("two_body_gravity_step_top regression: fail");
         $finish;
      end
   end

   initial begin
      logic [47:0] px, py;
      int sent;
      g_frac = GRAV_RESET;
      mass_a = MASS_ONE_RESET;
      mass_b = MASS_TWO_RESET;
      for (int i = 0; i < 4; i++) begin
         body_pos[i] = 0;
         body_vel[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      plan.push_back(row(0, 0, 0, 0, 0, 0, 1, 1, ST_COINCIDENT));
      plan.push_back(row(1, 0, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 0, 1, ST_LOADED));
      plan.push_back(row(1, 1, POS_MIN, POS_MIN, POS_MIN, POS_MIN, 0, 1, ST_LOADED));
      plan.push_back(row(0, 0, 0, 0, 0, 0, 0, 1, ST_STEPPED));
      plan.push_back(row(0, 0, 0, 0, 0, 0, 24'hFFFFFF, 1, ST_SATURATED));
      plan.push_back(row(1, 0, 0, 0, 0, 0, 0, 1, ST_LOADED));
      plan.push_back(row(1, 1, 0, 0, 0, 0, 0, 1, ST_LOADED));
      plan.push_back(row(0, 0, 0, 0, 0, 0, 24'hFFFFFF, 1, ST_COINCIDENT));
      plan.push_back(row(1, 1, 48'h10000, 0, 0, 0, 0, 0, ST_LOADED));
      plan.push_back(row(0, 0, 0, 0, 0, 0, 24'h10000, 0, ST_STEPPED));
      plan.push_back(row(1, 1, 0, -48'sh10000, 0, 0, 0, 0, ST_LOADED));
      plan.push_back(row(0, 0, 0, 0, 0, 0, 24'h8000, 0, ST_STEPPED));
      plan.push_back(row(1, 0, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                         48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 24'h555555, 0, ST_LOADED));
      plan.push_back(row(1, 1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                         48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 24'hAAAAAA, 0, ST_LOADED));
      plan.push_back(row(0, 1, 0, 0, 0, 0, 24'hAAAAAA, 0, ST_STEPPED));
      plan.push_back(row(0, 0, 0, 0, 0, 0, 24'h555555, 0, ST_STEPPED));
      foreach (plan[i]) send(plan[i]);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               csr_write(CSR_GRAV, 32'hFFFF_FFFF);
               csr_write(CSR_MASS_ONE, 32'hFFFF_FFFF);
               csr_write(CSR_MASS_TWO, 32'hFFFF_FFFF);
            end
            2: begin
               csr_write(CSR_GRAV, 0);
               csr_write(CSR_MASS_ONE, 1);
               csr_write(CSR_MASS_TWO, 1);
            end
            3: begin
               csr_write(CSR_SPARE, $urandom);
               csr_write(CSR_GRAV, $urandom);
               csr_write(CSR_MASS_ONE, $urandom_range(1, 32'hFFFF_FFFF));
               csr_write(CSR_MASS_TWO, $urandom_range(1, 32'hFFFF_FFFF));
            end
            4: begin
               quiet = 1;
               csr_write(CSR_GRAV, GRAV_RESET);
               csr_write(CSR_MASS_ONE, MASS_ONE_RESET);
               csr_write(CSR_MASS_TWO, MASS_TWO_RESET);
            end
            default: ;
         endcase
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray word of either kind
               send(row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_fix(),
                        rand_fix(), rand_fix(), rand_fix(), rand_dt(), 0, ST_STEPPED));
               sent++;
            end else begin
               px = rand_fix();
               py = rand_fix();
               send(row(1, 0, px, py, rand_fix(), rand_fix(), rand_dt(), 0, ST_LOADED));
               if ($urandom_range(0, 7) != 0) begin
                  px = rand_fix();
                  py = rand_fix();
               end
               send(row(1, 1, px, py, rand_fix(), rand_fix(), rand_dt(), 0, ST_LOADED));
               sent += 2;
               repeat ($urandom_range(2, 6)) begin
                  send(row(0, 1'($urandom_range(0, 1)), rand_fix(), rand_fix(), rand_fix(),
                           rand_fix(), rand_dt(), 0, ST_STEPPED));
                  sent++;
               end
            end
         end
      end
      @(negedge clock);
      req_valid = 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("two_body_gravity_step_top regression: pass");
      else
         $display("two_body_gravity_step_top regression: fail");
      $finish;
   end

endmodule
